@@ sv/rect_sum_point_set_table_core_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef RECT_SUM_POINT_SET_TABLE_CORE_DEFINES_SVH
`define RECT_SUM_POINT_SET_TABLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Antecedent holds: consequent holds in the same cycle.
`define RSPTAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent holds: consequent holds in the next cycle.
`define RSPTAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSPTAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RSPTAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/rsptab_pkg.sv @@
package rsptab_pkg;

    localparam int SIDE_DEF = 64;
    localparam int XW       = 6;
    localparam int VW       = 16;
    localparam int SUMW     = 28;
    localparam int SW       = 11;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic set_wr;
        logic row_step;
        logic col_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic set_ok;
        logic qry_empty;
        logic clr_last;
        logic set_last;
        logic row_active;
        logic row_odd;
        logic col_active;
    } t_sts;

endpackage

@@ sv/rsptab_ram.sv @@
module rsptab_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [W-1:0]             o_rdata_a,
    output logic [W-1:0]             o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ sv/rsptab_ctrl.sv @@
module rsptab_ctrl
    import rsptab_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_kind,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready,
    output logic o_valid
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SET_RD, S_SET_WR, S_ROW, S_COL, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   n_valid;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_kind) begin
                        n_state = i_sts.set_ok ? S_SET_RD : S_IDLE;
                    end else begin
                        n_state = i_sts.qry_empty ? S_FIN : S_ROW;
                    end
                end
            end
            S_SET_RD: n_state = S_SET_WR;
            S_SET_WR: begin
                o_cmd.set_wr = 1'b1;
                n_state = i_sts.set_last ? S_IDLE : S_SET_RD;
            end
            S_ROW: begin
                if (!i_sts.row_active) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.row_step = 1'b1;
                    if (i_sts.row_odd) begin
                        n_state = S_COL;
                    end
                end
            end
            S_COL: begin
                if (i_sts.col_active) begin
                    o_cmd.col_step = 1'b1;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_FIN: begin
                if (!o_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = o_valid;
        if (o_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= n_valid;
        end
    end

endmodule

@@ sv/rsptab_dp.sv @@
module rsptab_dp
    import rsptab_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic [XW-1:0]   i_row_first,
    input  logic [XW-1:0]   i_col_first,
    input  logic [XW-1:0]   i_row_last,
    input  logic [XW-1:0]   i_col_last,
    input  logic [VW-1:0]   i_cell_value,
    output t_sts            o_sts,
    output logic            o_we,
    output logic [SUMW-1:0] o_rect_sum
);

    localparam int LOG   = $clog2(SIDE);
    localparam int NW    = LOG + 1;
    localparam int CW    = NW + 1;
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 2 ** AW;
    localparam logic [SW-1:0] SIDE_V = SW'(SIDE);

    logic [SW-1:0]   w_r0, w_c0, w_r1, w_c1;
    logic [NW-1:0]   w_r0_leaf, w_c0_leaf, w_r1_leaf, w_c1_leaf;

    logic [NW-1:0]   r_set_r, r_set_k, r_c_leaf, r_cur;
    logic [CW-1:0]   r_rlo, r_rhi, r_clo, r_chi, r_c_lo0, r_c_hi0, w_chi_m1, w_rhi_m1;
    logic [VW-1:0]   r_value;
    logic [AW-1:0]   r_clr;
    logic            r_en_a, r_en_b;
    logic [SUMW-1:0] r_acc;

    logic [AW-1:0]   w_raddr_a, w_raddr_b, w_waddr;
    logic [SUMW-1:0] w_rd_a, w_rd_b, w_wdata, w_add_a, w_add_b;
    logic            w_row_leaf, w_col_leaf;

    // Clip the last row and column to the grid.
    assign w_r0 = SW'(i_row_first);
    assign w_c0 = SW'(i_col_first);
    assign w_r1 = (SW'(i_row_last) >= SIDE_V) ? SIDE_V - 1'b1 : SW'(i_row_last);
    assign w_c1 = (SW'(i_col_last) >= SIDE_V) ? SIDE_V - 1'b1 : SW'(i_col_last);

    assign w_r0_leaf = {1'b1, w_r0[LOG-1:0]};
    assign w_c0_leaf = {1'b1, w_c0[LOG-1:0]};
    assign w_r1_leaf = {1'b1, w_r1[LOG-1:0]};
    assign w_c1_leaf = {1'b1, w_c1[LOG-1:0]};

    assign w_row_leaf = r_set_r[LOG];
    assign w_col_leaf = r_set_k[LOG];
    assign w_chi_m1   = r_chi - 1'b1;
    assign w_rhi_m1   = r_rhi - 1'b1;

    assign o_sts.set_ok     = (w_r0 < SIDE_V) && (w_c0 < SIDE_V);
    assign o_sts.qry_empty  = (w_r0 > w_r1) || (w_c0 > w_c1);
    assign o_sts.clr_last   = &r_clr;
    assign o_sts.set_last   = (r_set_r == NW'(1)) && (r_set_k == NW'(1));
    assign o_sts.row_active = r_rlo < r_rhi;
    assign o_sts.row_odd    = r_rlo[0] || r_rhi[0];
    assign o_sts.col_active = r_clo < r_chi;

    always_comb begin
        if (i_cmd.col_step) begin
            w_raddr_a = {r_cur, r_clo[NW-1:0]};
            w_raddr_b = {r_cur, w_chi_m1[NW-1:0]};
        end else if (w_col_leaf) begin
            // Column leaf on an inner row: take the two row children.
            w_raddr_a = {r_set_r[LOG-1:0], 1'b0, r_set_k};
            w_raddr_b = {r_set_r[LOG-1:0], 1'b1, r_set_k};
        end else begin
            w_raddr_a = {r_set_r, r_set_k[LOG-1:0], 1'b0};
            w_raddr_b = {r_set_r, r_set_k[LOG-1:0], 1'b1};
        end
    end

    assign o_we    = i_cmd.clr_step || i_cmd.set_wr;
    assign w_waddr = i_cmd.clr_step ? r_clr : {r_set_r, r_set_k};
    assign w_wdata = i_cmd.clr_step ? '0 :
                     (w_row_leaf && w_col_leaf) ? SUMW'(r_value) : w_rd_a + w_rd_b;

    assign w_add_a = r_en_a ? w_rd_a : '0;
    assign w_add_b = r_en_b ? w_rd_b : '0;

    rsptab_ram #(
        .W     (SUMW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (o_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_en_a <= 1'b0;
            r_en_b <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            r_en_a <= i_cmd.col_step && r_clo[0];
            r_en_b <= i_cmd.col_step && r_chi[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set_r  <= w_r0_leaf;
            r_set_k  <= w_c0_leaf;
            r_c_leaf <= w_c0_leaf;
            r_value  <= i_cell_value;
            r_rlo    <= {1'b0, w_r0_leaf};
            r_rhi    <= {1'b0, w_r1_leaf} + 1'b1;
            r_c_lo0  <= {1'b0, w_c0_leaf};
            r_c_hi0  <= {1'b0, w_c1_leaf} + 1'b1;
            r_acc    <= '0;
        end else begin
            r_acc <= r_acc + w_add_a + w_add_b;
        end

        // Advance the update walk: up the columns, then one row up.
        if (i_cmd.set_wr) begin
            if (r_set_k == NW'(1)) begin
                r_set_k <= r_c_leaf;
                r_set_r <= r_set_r >> 1;
            end else begin
                r_set_k <= r_set_k >> 1;
            end
        end

        if (i_cmd.row_step) begin
            if (r_rlo[0]) begin
                r_cur <= r_rlo[NW-1:0];
                r_rlo <= r_rlo + 1'b1;
            end else if (r_rhi[0]) begin
                r_cur <= w_rhi_m1[NW-1:0];
                r_rhi <= w_rhi_m1;
            end else begin
                r_rlo <= r_rlo >> 1;
                r_rhi <= r_rhi >> 1;
            end
            r_clo <= r_c_lo0;
            r_chi <= r_c_hi0;
        end

        if (i_cmd.col_step) begin
            r_clo <= (r_clo + CW'(r_clo[0])) >> 1;
            r_chi <= (r_chi - CW'(r_chi[0])) >> 1;
        end

        if (i_cmd.out_load) begin
            o_rect_sum <= r_acc;
        end
    end

endmodule

@@ sv/rect_sum_point_set_table_core.sv @@
// Rectangle sum table over a SIDE x SIDE grid of 16-bit cells, kept as a
// two-dimensional segment tree in one RAM of 4*TN*TN 28-bit node sums (TN is
// SIDE rounded up to a power of two). After reset a clearing pass zeroes the
// RAM one node per cycle, with no input beat taken. A set beat writes one
// cell and refreshes all (log2(TN)+1)^2 covering nodes, each in a read
// state that fetches both children and then a write state; a set outside
// the grid is dropped and gives no result. A query beat walks the row
// nodes that cover the rows and, for each, the column nodes that cover the
// columns, one column step per cycle with two RAM reads. After the load,
// each row step either visits a row node, followed by its column steps, or
// shifts a row level up; a final row check and the result load follow,
// and then the result waits on i_ready. It returns one rect_sum beat. An
// empty rectangle skips the walk and gives zero.
// One item is worked at a time; the result register holds a finished sum
// while the next item is taken.
module rect_sum_point_set_table_core
    import rsptab_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_kind,
    input  logic [XW-1:0]   i_row_first,
    input  logic [XW-1:0]   i_col_first,
    input  logic [XW-1:0]   i_row_last,
    input  logic [XW-1:0]   i_col_last,
    input  logic [VW-1:0]   i_cell_value,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [SUMW-1:0] o_rect_sum
);

`include "rect_sum_point_set_table_core_defines.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_we;

    // Sequence clearing, update walks and query walks.
    rsptab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (o_ready),
        .o_valid (o_valid)
    );

    // Hold node indexes, the tree RAM, the running sum and the result.
    rsptab_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_row_first  (i_row_first),
        .i_col_first  (i_col_first),
        .i_row_last   (i_row_last),
        .i_col_last   (i_col_last),
        .i_cell_value (i_cell_value),
        .o_sts        (w_sts),
        .o_we         (w_we),
        .o_rect_sum   (o_rect_sum)
    );

    // A set beat never raises a result.
    `RSPTAB_ASSERT_NXT(a_set_no_result, i_clk, i_rst_n, i_valid && o_ready && !i_kind && !o_valid, !o_valid)
    // The tree is written only while no input beat can be taken.
    `RSPTAB_ASSERT_IMP(a_write_busy, i_clk, i_rst_n, w_we, !o_ready)
    // A query beat leaves the block busy in the cycle after it is taken.
    `RSPTAB_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, i_valid && o_ready && i_kind, !o_ready)

endmodule

@@ dv/rect_sum_point_set_table_core_test.sv @@
module rect_sum_point_set_table_core_test;
    import rsptab_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_N    = SIDE_DEF;
    localparam int LEAVES    = 64;
    localparam int IDLE_MAX  = 80000;
    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic            i_kind;
    logic [XW-1:0]   i_row_first;
    logic [XW-1:0]   i_col_first;
    logic [XW-1:0]   i_row_last;
    logic [XW-1:0]   i_col_last;
    logic [VW-1:0]   i_cell_value;
    logic            o_valid;
    logic            i_ready;
    logic [SUMW-1:0] o_rect_sum;

    rect_sum_point_set_table_core #(.SIDE(SIDE_N)) u_top (.*);

    // Shadow of the grid; node sums are folded back into cells, since a
    // tree of exact sums equals the plain sum over the cells it covers.
    logic [VW-1:0]   grid_cells [LEAVES][LEAVES];
    logic [SUMW-1:0] pending_sums [$];
    int              fail_count;
    int              idle_cycles;
    int              set_count;
    int              query_count;
    int              sum_count;
    int              ready_hold;
    bit              stall_enable;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Apply one beat to the shadow grid and queue any sum it produces.
    function automatic void predict_beat(logic kind, logic [XW-1:0] r0, logic [XW-1:0] c0,
                                         logic [XW-1:0] r1, logic [XW-1:0] c1,
                                         logic [VW-1:0] value);
        int unsigned last_r;
        int unsigned last_c;
        logic [31:0] total;
        total = '0;
        if (kind == KIND_SET) begin
            // Drop sets that land off the grid.
            if (r0 < SIDE_N && c0 < SIDE_N) begin
                grid_cells[r0][c0] = value;
            end
            return;
        end
        last_r = (r1 >= SIDE_N) ? SIDE_N - 1 : r1;
        last_c = (c1 >= SIDE_N) ? SIDE_N - 1 : c1;
        if (r0 <= last_r && c0 <= last_c) begin
            for (int r = r0; r <= last_r; r++) begin
                for (int c = c0; c <= last_c; c++) begin
                    total += grid_cells[r][c];
                end
            end
        end
        pending_sums.push_back(total[SUMW-1:0]);
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 200);
    endfunction

    // Send one beat, hold it until accepted, then keep the prediction in step.
    // Valid stays high across back-to-back beats and drops only for a gap.
    task automatic send_beat(logic kind, logic [XW-1:0] r0, logic [XW-1:0] c0,
                             logic [XW-1:0] r1, logic [XW-1:0] c1, logic [VW-1:0] value);
        int gap;
        gap = stall_enable ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_row_first  <= r0;
        i_col_first  <= c0;
        i_row_last   <= r1;
        i_col_last   <= c1;
        i_cell_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_beat(kind, r0, c0, r1, c1, value);
        if (kind == KIND_SET) set_count++;
        else query_count++;
    endtask

    task automatic send_set(int r, int c, int value);
        send_beat(KIND_SET, XW'(r), XW'(c), XW'($urandom), XW'($urandom), VW'(value));
    endtask

    task automatic send_query(int r0, int c0, int r1, int c1);
        send_beat(KIND_QUERY, XW'(r0), XW'(c0), XW'(r1), XW'(c1), VW'($urandom));
    endtask

    // Receiver: ready high with stalls off, else random with rare long stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (!stall_enable) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            i_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < 2) begin
            i_ready    <= 1'b0;
            ready_hold <= $urandom_range(20, 200);
        end else begin
            i_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Compare every result beat with the oldest predicted sum.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sum_count++;
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected rect_sum beat, actual %0d", $time, o_rect_sum);
                fail_count++;
            end else begin
                logic [SUMW-1:0] want;
                want = pending_sums.pop_front();
                if (o_rect_sum !== want) begin
                    $display("%0t: rect_sum expected %0d actual %0d", $time, want, o_rect_sum);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("%0t: watchdog expired", $time);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Corners, edges, full value range and empty queries.
    task automatic test_directed();
        send_query(0, 0, 63, 63);
        send_set(0, 0, 16'hFFFF);
        send_set(63, 63, 16'hFFFF);
        send_set(0, 63, 16'h0001);
        send_set(63, 0, 16'h8000);
        send_set(31, 32, 16'h5555);
        send_set(32, 31, 16'hAAAA);
        send_query(0, 0, 63, 63);
        send_query(0, 0, 0, 0);
        send_query(63, 63, 63, 63);
        send_query(31, 31, 32, 32);
        send_query(10, 0, 9, 63);
        send_query(0, 10, 63, 9);
        send_query(0, 0, 63, 0);
        send_query(0, 63, 0, 63);
        send_set(0, 0, 0);
        send_query(0, 0, 1, 1);
        send_query(42, 21, 42, 21);
        send_set(21, 42, 16'h1234);
        send_query(0, 0, 63, 63);
        send_query(21, 42, 21, 42);
    endtask

    // Set the diagonal and a sparse set of cells to the top value; query all.
    task automatic test_full_grid();
        for (int r = 0; r < SIDE_N; r++) begin
            for (int c = 0; c < SIDE_N; c++) begin
                if (((r * 7 + c) % 61) == 0 || r == c) send_set(r, c, 16'hFFFF);
            end
        end
        send_query(0, 0, 63, 63);
    endtask

    // Coin-flip sets and queries; both sides stall, save each third 60 beats.
    task automatic test_random(int beats);
        for (int n = 0; n < beats; n++) begin
            int r0, c0, r1, c1;
            r0 = $urandom_range(0, 63);
            c0 = $urandom_range(0, 63);
            if ($urandom_range(0, 9) < 7) begin
                r1 = $urandom_range(r0, 63);
                c1 = $urandom_range(c0, 63);
            end else begin
                r1 = $urandom_range(0, 63);
                c1 = $urandom_range(0, 63);
            end
            stall_enable = ((n / 60) % 3) != 2;
            if ($urandom_range(0, 1)) send_set(r0, c0, $urandom);
            else send_query(r0, c0, r1, c1);
        end
    endtask

    initial begin
        for (int r = 0; r < LEAVES; r++) begin
            for (int c = 0; c < LEAVES; c++) grid_cells[r][c] = '0;
        end
        fail_count   = 0;
        idle_cycles  = 0;
        set_count    = 0;
        query_count  = 0;
        sum_count    = 0;
        ready_hold   = 0;
        stall_enable = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = KIND_SET;
        i_row_first  = '0;
        i_col_first  = '0;
        i_row_last   = '0;
        i_col_last   = '0;
        i_cell_value = '0;
        i_ready      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        stall_enable = 1'b1;
        test_full_grid();
        test_random(320);
        i_valid <= 1'b0;

        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Covered %0d set beats and %0d query beats, %0d sums checked.",
                 set_count, query_count, sum_count);
        if (fail_count == 0 && pending_sums.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/rsptab_pkg.sv
sv/rsptab_ram.sv
sv/rsptab_ctrl.sv
sv/rsptab_dp.sv
sv/rect_sum_point_set_table_core.sv
dv/rect_sum_point_set_table_core_test.sv
